// ===== src/lef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lef_pkg
// Shared types, codes and widths of the leader election block.
// ----------------------------------------------------------------------------
package lef_pkg;

   localparam int PEERS_DEFAULT = 16;
   localparam int CMD_W         = 3;
   localparam int PIDX_W        = 4;
   localparam int TERM_W        = 32;
   localparam int ID_W          = 16;
   localparam int MASK_W        = 16;
   localparam int QUORUM_W      = 5;
   localparam int TIMEOUT_W     = 3;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [QUORUM_W-1:0]  VOTES_MAX       = 5'd31;
   localparam logic [QUORUM_W-1:0]  QUORUM_RESET    = 5'd1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 3'd2;
   localparam logic [TIMEOUT_W-1:0] HEARTBEAT_RELOAD = 3'd1;

   // command codes on req_cmd
   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PEER_UP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEER_DOWN = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_VOTE_REQ  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_VOTE_RSP  = 3'd5;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUORUM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd2;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_PEER_UP,
      OP_PEER_DOWN,
      OP_HEARTBEAT,
      OP_VOTE_REQ,
      OP_VOTE_RSP,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      ROLE_FOLLOWER  = 2'd0,
      ROLE_CANDIDATE = 2'd1,
      ROLE_LEADER    = 2'd2
   } role_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_VOTE  = 2'd1,
      KIND_HEART = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      EVT_NONE      = 2'd0,
      EVT_LEADER    = 2'd1,
      EVT_STEP_DOWN = 2'd2
   } event_type;

   typedef struct packed {
      op_type              op;
      logic                peer_ok;
      logic [PIDX_W-1:0]   peer_index;
      logic [TERM_W-1:0]   msg_term;
      logic [ID_W-1:0]     msg_leader;
      logic                vote_in;
   } cmd_word_type;

   typedef struct packed {
      logic                  enable;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

endpackage

// ===== src/lef_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lef_front
// Decodes an incoming event into an operation word for the queue.
// ----------------------------------------------------------------------------
module lef_front #(
   parameter int PEERS = lef_pkg::PEERS_DEFAULT
) (
   input  logic [lef_pkg::CMD_W-1:0]  req_cmd,
   input  logic [lef_pkg::PIDX_W-1:0] req_peer_index,
   input  logic [lef_pkg::TERM_W-1:0] req_msg_term,
   input  logic [lef_pkg::ID_W-1:0]   req_msg_leader,
   input  logic                       req_vote_in,
   output lef_pkg::cmd_word_type      word
);
   import lef_pkg::*;

   op_type op;

   always_comb begin
      case (req_cmd)
         CMD_TICK:      op = OP_TICK;
         CMD_PEER_UP:   op = OP_PEER_UP;
         CMD_PEER_DOWN: op = OP_PEER_DOWN;
         CMD_HEARTBEAT: op = OP_HEARTBEAT;
         CMD_VOTE_REQ:  op = OP_VOTE_REQ;
         CMD_VOTE_RSP:  op = OP_VOTE_RSP;
         default:       op = OP_NOP;
      endcase
   end

   always_comb begin
      word.op         = op;
      // peers past the configured count never touch the mask
      word.peer_ok    = (int'(req_peer_index) < PEERS);
      word.peer_index = req_peer_index;
      word.msg_term   = req_msg_term;
      word.msg_leader = req_msg_leader;
      word.vote_in    = req_vote_in;
   end

endmodule

// ===== src/lef_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lef_queue
// Two-entry queue of decoded words between front and back.
// ----------------------------------------------------------------------------
module lef_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  lef_pkg::cmd_word_type push_word,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output lef_pkg::cmd_word_type pop_word
);
   import lef_pkg::*;

   cmd_word_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== src/lef_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lef_back
// Election state, config registers and the registered response word.
// ----------------------------------------------------------------------------
module lef_back #(
   parameter int PEERS = lef_pkg::PEERS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lef_pkg::csr_wr_type        csr,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  lef_pkg::cmd_word_type      in_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_send_kind,
   output logic [lef_pkg::MASK_W-1:0] rsp_send_mask,
   output logic [lef_pkg::TERM_W-1:0] rsp_send_term,
   output logic                       rsp_vote_granted,
   output logic [1:0]                 rsp_role,
   output logic [1:0]                 rsp_role_event
);
   import lef_pkg::*;

   // config; own_id is accepted on the port but nothing here reads it
   logic [QUORUM_W-1:0]  quorum_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   role_type             role_ff, role_in;
   logic [TERM_W-1:0]    term_ff, term_in;
   logic [QUORUM_W-1:0]  votes_ff, votes_in;
   logic [ID_W-1:0]      leader_ff, leader_in;
   logic [PEERS-1:0]     peer_mask_ff, peer_mask_in;
   logic [TIMEOUT_W-1:0] ticks_ff, ticks_in;
   logic                 running_ff, running_in;
   logic                 hb_mode_ff, hb_mode_in;

   logic                 rsp_valid_ff;
   kind_type             rsp_kind_ff;
   logic [MASK_W-1:0]    rsp_mask_ff;
   logic [TERM_W-1:0]    rsp_term_ff;
   logic                 rsp_grant_ff;
   role_type             rsp_role_ff;
   event_type            rsp_event_ff;

   kind_type             kind;
   event_type            evt;
   logic                 grant;
   logic                 fire;
   logic [PEERS-1:0]     peer_bit;
   logic [MASK_W-1:0]    mask_out;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      peer_bit = '0;
      for (int i = 0; i < PEERS; i++) begin
         peer_bit[i] = in_word.peer_ok && (int'(in_word.peer_index) == i);
      end
   end

   always_comb begin
      role_in      = role_ff;
      term_in      = term_ff;
      votes_in     = votes_ff;
      leader_in    = leader_ff;
      peer_mask_in = peer_mask_ff;
      ticks_in     = ticks_ff;
      running_in   = running_ff;
      hb_mode_in   = hb_mode_ff;
      kind         = KIND_NONE;
      evt          = EVT_NONE;
      grant        = 1'b0;
      case (in_word.op)
         OP_TICK: begin
            if (running_ff) begin
               if (ticks_ff > 3'd1) begin
                  ticks_in = ticks_ff - 3'd1;
               end else if (hb_mode_ff) begin
                  kind     = KIND_HEART;
                  ticks_in = HEARTBEAT_RELOAD;
               end else begin
                  // election timeout: stand as candidate with own vote
                  term_in  = term_ff + 32'd1;
                  role_in  = ROLE_CANDIDATE;
                  votes_in = 5'd1;
                  kind     = KIND_VOTE;
                  ticks_in = timeout_ff;
               end
            end
         end
         OP_PEER_UP: begin
            peer_mask_in = peer_mask_ff | peer_bit;
            if (!running_ff) begin
               ticks_in   = timeout_ff;
               running_in = 1'b1;
            end
         end
         OP_PEER_DOWN: begin
            peer_mask_in = peer_mask_ff & ~peer_bit;
         end
         OP_HEARTBEAT: begin
            if (in_word.msg_term >= term_ff) begin
               case (role_ff)
                  ROLE_FOLLOWER: begin
                     ticks_in   = timeout_ff;
                     running_in = 1'b1;
                  end
                  ROLE_CANDIDATE: begin
                     ticks_in   = timeout_ff;
                     running_in = 1'b1;
                     role_in    = ROLE_FOLLOWER;
                     term_in    = in_word.msg_term;
                     leader_in  = in_word.msg_leader;
                     votes_in   = '0;
                  end
                  default: begin
                     // leader steps down only for a strictly newer term
                     if (in_word.msg_term != term_ff) begin
                        role_in    = ROLE_FOLLOWER;
                        ticks_in   = timeout_ff;
                        running_in = 1'b1;
                        hb_mode_in = 1'b0;
                        evt        = EVT_STEP_DOWN;
                     end
                  end
               endcase
            end
         end
         OP_VOTE_REQ: begin
            if (in_word.msg_term > term_ff) begin
               grant   = 1'b1;
               term_in = in_word.msg_term;
            end
         end
         OP_VOTE_RSP: begin
            if (in_word.vote_in && (role_ff == ROLE_CANDIDATE)) begin
               if (votes_ff != VOTES_MAX) begin
                  votes_in = votes_ff + 5'd1;
               end
               if (votes_in >= quorum_ff) begin
                  role_in    = ROLE_LEADER;
                  kind       = KIND_HEART;
                  ticks_in   = HEARTBEAT_RELOAD;
                  running_in = 1'b1;
                  hb_mode_in = 1'b1;
                  evt        = EVT_LEADER;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mask_out = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (i < PEERS) begin
            mask_out[i] = peer_mask_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quorum_ff  <= QUORUM_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr.enable) begin
         case (csr.index)
            CSR_QUORUM:  quorum_ff  <= csr.data[QUORUM_W-1:0];
            CSR_TIMEOUT: timeout_ff <= csr.data[TIMEOUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff      <= ROLE_FOLLOWER;
         term_ff      <= '0;
         votes_ff     <= '0;
         leader_ff    <= '0;
         peer_mask_ff <= '0;
         ticks_ff     <= '0;
         running_ff   <= 1'b0;
         hb_mode_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            role_ff      <= role_in;
            term_ff      <= term_in;
            votes_ff     <= votes_in;
            leader_ff    <= leader_in;
            peer_mask_ff <= peer_mask_in;
            ticks_ff     <= ticks_in;
            running_ff   <= running_in;
            hb_mode_ff   <= hb_mode_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_kind_ff  <= kind;
         rsp_mask_ff  <= (kind != KIND_NONE) ? mask_out : '0;
         rsp_term_ff  <= (kind != KIND_NONE) ? term_in : '0;
         rsp_grant_ff <= grant;
         rsp_role_ff  <= role_in;
         rsp_event_ff <= evt;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_send_kind    = rsp_kind_ff;
   assign rsp_send_mask    = rsp_mask_ff;
   assign rsp_send_term    = rsp_term_ff;
   assign rsp_vote_granted = rsp_grant_ff;
   assign rsp_role         = rsp_role_ff;
   assign rsp_role_event   = rsp_event_ff;

   // heartbeat timing is used exactly while leading
   a_hb_mode_leader : assert property (@(posedge clock) disable iff (reset)
      hb_mode_ff == (role_ff == ROLE_LEADER))
      else $error("heartbeat mode out of step with leader role");

   a_timer_idle_zero : assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (ticks_ff == '0))
      else $error("countdown loaded while timer stopped");

   a_elected_word : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_ff == EVT_LEADER)) |->
         ((rsp_role_ff == ROLE_LEADER) && (rsp_kind_ff == KIND_HEART)))
      else $error("election word without leader heartbeat");

   a_quiet_word : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_NONE)) |->
         ((rsp_mask_ff == '0) && (rsp_term_ff == '0)))
      else $error("broadcast fields set on a word with no broadcast");

endmodule

// ===== src/leader_election_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leader_election_fsm
// Raft-style leader election for one node: role, term, votes and timer.
// ----------------------------------------------------------------------------
// Path: a response word becomes valid after its request has passed the queue
// entry, then the registered state update; it is taken when rsp_ready is high.
// Throughput: one word per cycle sustained while rsp_ready stays high; the
// back-end state update sets this; a two-entry queue decouples it from intake.
// Reset (synchronous): follower, term 0, all peers down, timer stopped,
// quorum 1, election timeout 2, queue and response register empty.
module leader_election_fsm #(
   parameter int PEERS = lef_pkg::PEERS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lef_pkg::CMD_W-1:0]      req_cmd,
   input  logic [lef_pkg::PIDX_W-1:0]     req_peer_index,
   input  logic [lef_pkg::TERM_W-1:0]     req_msg_term,
   input  logic [lef_pkg::ID_W-1:0]       req_msg_leader,
   input  logic                           req_vote_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_send_kind,
   output logic [lef_pkg::MASK_W-1:0]     rsp_send_mask,
   output logic [lef_pkg::TERM_W-1:0]     rsp_send_term,
   output logic                           rsp_vote_granted,
   output logic [1:0]                     rsp_role,
   output logic [1:0]                     rsp_role_event,
   input  logic                           csr_write_enable,
   input  logic [lef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lef_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import lef_pkg::*;

   cmd_word_type front_word;
   cmd_word_type back_word;
   logic         back_valid;
   logic         back_ready;
   csr_wr_type   csr;

   assign csr.enable = csr_write_enable;
   assign csr.index  = csr_index;
   assign csr.data   = csr_write_data;

   lef_front #(
      .PEERS (PEERS)
   ) u_front (
      .req_cmd        (req_cmd),
      .req_peer_index (req_peer_index),
      .req_msg_term   (req_msg_term),
      .req_msg_leader (req_msg_leader),
      .req_vote_in    (req_vote_in),
      .word           (front_word)
   );

   lef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_word  (front_word),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_word   (back_word)
   );

   lef_back #(
      .PEERS (PEERS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr),
      .in_valid         (back_valid),
      .in_ready         (back_ready),
      .in_word          (back_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_send_kind    (rsp_send_kind),
      .rsp_send_mask    (rsp_send_mask),
      .rsp_send_term    (rsp_send_term),
      .rsp_vote_granted (rsp_vote_granted),
      .rsp_role         (rsp_role),
      .rsp_role_event   (rsp_role_event)
   );

endmodule

// ===== verif/leader_election_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leader_election_checker
// Watches the request, response and register ports of the election block,
// keeps its own copy of the node state, predicts the response word for each
// accepted request and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module leader_election_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [lef_pkg::CMD_W-1:0]      req_cmd,
   input  logic [lef_pkg::PIDX_W-1:0]     req_peer_index,
   input  logic [lef_pkg::TERM_W-1:0]     req_msg_term,
   input  logic [lef_pkg::ID_W-1:0]       req_msg_leader,
   input  logic                           req_vote_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [1:0]                     rsp_send_kind,
   input  logic [lef_pkg::MASK_W-1:0]     rsp_send_mask,
   input  logic [lef_pkg::TERM_W-1:0]     rsp_send_term,
   input  logic                           rsp_vote_granted,
   input  logic [1:0]                     rsp_role,
   input  logic [1:0]                     rsp_role_event,
   input  logic                           csr_write_enable,
   input  logic [lef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lef_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int unsigned                    fail_count,
   output int unsigned                    outstanding,
   output logic [lef_pkg::TERM_W-1:0]     term_hint
);
   import lef_pkg::*;

   localparam int PEERS = PEERS_DEFAULT;

   typedef struct packed {
      kind_type            kind;
      logic [MASK_W-1:0]   mask;
      logic [TERM_W-1:0]   term;
      logic                granted;
      role_type            role;
      event_type           evt;
   } election_outcome_type;

   election_outcome_type expected_outcomes[$];
   int unsigned          errors = 0;

   // node state
   role_type              node_role;
   logic [TERM_W-1:0]     term;
   logic [QUORUM_W-1:0]   votes;
   logic [ID_W-1:0]       leader_id;
   logic [MASK_W-1:0]     peers_up;
   logic [TIMEOUT_W-1:0]  ticks_left;
   logic                  timer_on;
   logic                  hb_mode;

   // register copies; own id never shows up in a response
   logic [QUORUM_W-1:0]   quorum_cfg;
   logic [TIMEOUT_W-1:0]  timeout_cfg;

   assign fail_count = errors;

   function automatic void arm_timer(input logic [TIMEOUT_W-1:0] ticks);
      ticks_left = ticks;
      timer_on   = 1'b1;
   endfunction

   function automatic election_outcome_type step_node(
      input logic [CMD_W-1:0]  cmd,
      input logic [PIDX_W-1:0] pidx,
      input logic [TERM_W-1:0] mterm,
      input logic [ID_W-1:0]   mlead,
      input logic              vin
   );
      election_outcome_type o;
      o      = '0;
      o.kind = KIND_NONE;
      o.evt  = EVT_NONE;
      case (cmd)
         CMD_TICK: begin
            if (timer_on) begin
               if (ticks_left > 3'd1) begin
                  ticks_left = ticks_left - 3'd1;
               end else if (hb_mode) begin
                  o.kind = KIND_HEART;
                  arm_timer(HEARTBEAT_RELOAD);
               end else begin
                  // election timeout: new term, vote for self
                  term      = term + 32'd1;
                  node_role = ROLE_CANDIDATE;
                  votes     = 5'd1;
                  o.kind    = KIND_VOTE;
                  arm_timer(timeout_cfg);
               end
            end
         end
         CMD_PEER_UP: begin
            if (int'(pidx) < PEERS) peers_up[pidx] = 1'b1;
            if (!timer_on) arm_timer(timeout_cfg);
         end
         CMD_PEER_DOWN: begin
            if (int'(pidx) < PEERS) peers_up[pidx] = 1'b0;
         end
         CMD_HEARTBEAT: begin
            if (mterm >= term) begin
               if (node_role == ROLE_FOLLOWER) begin
                  arm_timer(timeout_cfg);
               end else if (node_role == ROLE_CANDIDATE) begin
                  arm_timer(timeout_cfg);
                  node_role = ROLE_FOLLOWER;
                  term      = mterm;
                  leader_id = mlead;
                  votes     = '0;
               end else if (mterm > term) begin
                  // leader sees a newer term and steps down, keeps its term
                  node_role = ROLE_FOLLOWER;
                  arm_timer(timeout_cfg);
                  hb_mode   = 1'b0;
                  o.evt     = EVT_STEP_DOWN;
               end
            end
         end
         CMD_VOTE_REQ: begin
            if (mterm > term) begin
               o.granted = 1'b1;
               term      = mterm;
            end
         end
         CMD_VOTE_RSP: begin
            if (vin && node_role == ROLE_CANDIDATE) begin
               if (votes < VOTES_MAX) votes = votes + 5'd1;
               if (votes >= quorum_cfg) begin
                  node_role = ROLE_LEADER;
                  o.kind    = KIND_HEART;
                  arm_timer(HEARTBEAT_RELOAD);
                  hb_mode   = 1'b1;
                  o.evt     = EVT_LEADER;
               end
            end
         end
         default: ;
      endcase
      if (o.kind != KIND_NONE) begin
         o.mask = peers_up;
         o.term = term;
      end
      o.role = node_role;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      election_outcome_type want;
      if (reset) begin
         node_role   = ROLE_FOLLOWER;
         term        = '0;
         votes       = '0;
         leader_id   = '0;
         peers_up    = '0;
         ticks_left  = '0;
         timer_on    = 1'b0;
         hb_mode     = 1'b0;
         quorum_cfg  = QUORUM_RESET;
         timeout_cfg = TIMEOUT_RESET;
         expected_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("response word with no request pending");
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("send_kind", 32'(want.kind), 32'(rsp_send_kind));
               check_field("send_mask", 32'(want.mask), 32'(rsp_send_mask));
               check_field("send_term", want.term, rsp_send_term);
               check_field("vote_granted", 32'(want.granted), 32'(rsp_vote_granted));
               check_field("role", 32'(want.role), 32'(rsp_role));
               check_field("role_event", 32'(want.evt), 32'(rsp_role_event));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_QUORUM:  quorum_cfg  = csr_write_data[QUORUM_W-1:0];
               CSR_TIMEOUT: timeout_cfg = csr_write_data[TIMEOUT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_outcomes.insert(expected_outcomes.size(),
               step_node(req_cmd, req_peer_index, req_msg_term, req_msg_leader,
                         req_vote_in));
         end
      end
      outstanding <= expected_outcomes.size();
      term_hint   <= term;
   end

endmodule

// ===== verif/tb_leader_election_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_leader_election_fsm
// Drives election events into the block: a directed walk through the role
// changes, then random traffic and vote campaigns under several register
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_leader_election_fsm;
   import lef_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 156;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;
   localparam logic [CMD_W-1:0]     CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0]     CMD_SPARE7 = 3'd7;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd          = '0;
   logic [PIDX_W-1:0]     req_peer_index   = '0;
   logic [TERM_W-1:0]     req_msg_term     = '0;
   logic [ID_W-1:0]       req_msg_leader   = '0;
   logic                  req_vote_in      = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [1:0]            rsp_send_kind;
   logic [MASK_W-1:0]     rsp_send_mask;
   logic [TERM_W-1:0]     rsp_send_term;
   logic                  rsp_vote_granted;
   logic [1:0]            rsp_role;
   logic [1:0]            rsp_role_event;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   int unsigned           mismatches;
   int unsigned           outstanding;
   logic [TERM_W-1:0]     term_hint;
   int                    idle_cycles = 0;
   bit                    sender_calm = 1'b0;
   bit                    receiver_calm = 1'b0;

   leader_election_fsm u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_peer_index   (req_peer_index),
      .req_msg_term     (req_msg_term),
      .req_msg_leader   (req_msg_leader),
      .req_vote_in      (req_vote_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_send_kind    (rsp_send_kind),
      .rsp_send_mask    (rsp_send_mask),
      .rsp_send_term    (rsp_send_term),
      .rsp_vote_granted (rsp_vote_granted),
      .rsp_role         (rsp_role),
      .rsp_role_event   (rsp_role_event),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   leader_election_checker u_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_peer_index   (req_peer_index),
      .req_msg_term     (req_msg_term),
      .req_msg_leader   (req_msg_leader),
      .req_vote_in      (req_vote_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_send_kind    (rsp_send_kind),
      .rsp_send_mask    (rsp_send_mask),
      .rsp_send_term    (rsp_send_term),
      .rsp_vote_granted (rsp_vote_granted),
      .rsp_role         (rsp_role),
      .rsp_role_event   (rsp_role_event),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (mismatches),
      .outstanding      (outstanding),
      .term_hint        (term_hint)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // no progress on either channel for too long: hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // response side: random stall before each word, calm stretches now and then
   initial begin
      int stall;
      int words;
      words = 0;
      wait (reset == 1'b0);
      forever begin
         if (words % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
         words++;
         stall = receiver_calm ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PIDX_W-1:0] pidx,
                            input logic [TERM_W-1:0] mterm, input logic [ID_W-1:0] mlead,
                            input logic vin);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_peer_index <= pidx;
      req_msg_term   <= mterm;
      req_msg_leader <= mlead;
      req_vote_in    <= vin;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every response is back, so the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [ID_W-1:0] id, input logic [QUORUM_W-1:0] q,
                               input logic [TIMEOUT_W-1:0] tmo);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_OWN_ID;
      csr_write_data   <= id;
      @(posedge clock);
      // upper data bits are don't-care for the narrow registers
      csr_index        <= CSR_QUORUM;
      csr_write_data   <= {junk[15:5], q};
      @(posedge clock);
      csr_index        <= CSR_TIMEOUT;
      csr_write_data   <= {junk[15:3], tmo};
      @(posedge clock);
      csr_index        <= CSR_SPARE;
      csr_write_data   <= junk;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [TERM_W-1:0] pick_term();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         3, 4, 5: return term_hint - $urandom_range(0, 2);
         default: return term_hint + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic random_traffic(input int count, input logic [QUORUM_W-1:0] q);
      int                sent;
      int                pick;
      int                votes;
      logic [PIDX_W-1:0] pidx;
      logic [TERM_W-1:0] mterm;
      logic [ID_W-1:0]   mlead;
      logic              vin;
      sent = 0;
      while (sent < count) begin
         if (sent % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         pidx  = PIDX_W'($urandom);
         mterm = $urandom;
         mlead = ID_W'($urandom);
         vin   = 1'($urandom);
         if (pick < 8) begin
            // campaign: run the timer out, then a run of mostly granted votes
            repeat ($urandom_range(1, 4)) begin
               send_word(CMD_TICK, pidx, mterm, mlead, vin);
               sent++;
            end
            votes = $urandom_range(1, int'(q) + 3);
            repeat (votes) begin
               send_word(CMD_VOTE_RSP, pidx, mterm, mlead,
                         $urandom_range(0, 9) != 0);
               sent++;
            end
         end else begin
            if (pick < 33)
               send_word(CMD_TICK, pidx, mterm, mlead, vin);
            else if (pick < 45)
               send_word(CMD_PEER_UP, pidx, mterm, mlead, vin);
            else if (pick < 51)
               send_word(CMD_PEER_DOWN, pidx, mterm, mlead, vin);
            else if (pick < 67)
               send_word(CMD_VOTE_RSP, pidx, mterm, mlead,
                         $urandom_range(0, 5) != 0);
            else if (pick < 80)
               send_word(CMD_HEARTBEAT, pidx, pick_term(), mlead, vin);
            else if (pick < 94)
               send_word(CMD_VOTE_REQ, pidx, pick_term(), mlead, vin);
            else if (pick < 97)
               send_word(CMD_SPARE6, pidx, mterm, mlead, vin);
            else
               send_word(CMD_SPARE7, pidx, mterm, mlead, vin);
            sent++;
         end
      end
   endtask

   initial begin
      logic [ID_W-1:0]      id;
      logic [QUORUM_W-1:0]  q;
      logic [TIMEOUT_W-1:0] tmo;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk: follower -> candidate -> leader -> step down -> wrap
      program_regs(16'hFFFF, 5'd2, 3'd2);
      send_word(CMD_TICK,      4'd0,  32'd0,        16'd0,    1'b0); // timer stopped
      send_word(CMD_SPARE6,    4'd0,  32'd0,        16'd0,    1'b0);
      send_word(CMD_SPARE7,    4'hF,  '1,           '1,       1'b1);
      send_word(CMD_VOTE_RSP,  4'd0,  32'd0,        16'd0,    1'b1); // not candidate
      send_word(CMD_PEER_DOWN, 4'd0,  32'd0,        16'd0,    1'b0);
      send_word(CMD_PEER_UP,   4'd0,  32'd0,        16'd0,    1'b0); // starts timer
      send_word(CMD_PEER_UP,   4'hF,  32'd0,        16'd0,    1'b0);
      send_word(CMD_HEARTBEAT, 4'd0,  32'd0,        16'd9,    1'b0);
      send_word(CMD_TICK,      4'd0,  32'd0,        16'd0,    1'b0);
      send_word(CMD_TICK,      4'd0,  32'd0,        16'd0,    1'b0); // election
      send_word(CMD_VOTE_RSP,  4'd0,  32'd0,        16'd0,    1'b0); // refused
      send_word(CMD_VOTE_RSP,  4'd0,  32'd0,        16'd0,    1'b1); // quorum
      send_word(CMD_TICK,      4'd0,  32'd0,        16'd0,    1'b0); // heartbeat
      send_word(CMD_HEARTBEAT, 4'd0,  32'd0,        16'd3,    1'b0); // stale
      send_word(CMD_HEARTBEAT, 4'd0,  32'd1,        16'd3,    1'b0); // same term
      send_word(CMD_HEARTBEAT, 4'd0,  32'd5,        16'd3,    1'b0); // step down
      send_word(CMD_VOTE_REQ,  4'd0,  32'd1,        16'd0,    1'b0); // not newer
      send_word(CMD_VOTE_REQ,  4'd0,  32'hFFFFFFFF, 16'd0,    1'b0); // granted
      send_word(CMD_TICK,      4'd0,  32'd0,        16'd0,    1'b0);
      send_word(CMD_TICK,      4'd0,  32'd0,        16'd0,    1'b0); // term wraps
      send_word(CMD_HEARTBEAT, 4'd0,  32'd7,        16'hFFFF, 1'b0); // back to follower
      send_word(CMD_VOTE_RSP,  4'd0,  32'd0,        16'd0,    1'b1);
      send_word(CMD_PEER_DOWN, 4'hF,  32'd0,        16'd0,    1'b0);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         id  = ID_W'($urandom);
         q   = QUORUM_W'($urandom_range(0, 31));
         tmo = TIMEOUT_W'($urandom_range(0, 7));
         case (phase)
            0: begin id = 16'h0000; q = 5'd1;  tmo = 3'd2; end
            1: begin id = 16'hFFFF; q = 5'd31; tmo = 3'd7; end
            2: begin                q = 5'd0;  tmo = 3'd0; end // zero timeout
            3: begin                q = 5'd3;  tmo = 3'd4; end
            4: begin                q = 5'd17; tmo = 3'd1; end
            5: begin id = 16'hA5A5; q = 5'd2;  tmo = 3'd3; end
            7: begin id = 16'h5A5A; q = 5'd4;  tmo = 3'd2; end
            default: ;
         endcase
         program_regs(id, q, tmo);
         random_traffic(PHASE_WORDS, q);
         drain();
      end

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/lef_pkg.sv
src/lef_front.sv
src/lef_queue.sv
src/lef_back.sv
src/leader_election_fsm.sv
verif/leader_election_checker.sv
verif/tb_leader_election_fsm.sv
